[sv/base58_encoder_assert.svh]
// assertion macros shared by the base58 encoder rtl
`ifndef BASE58_ENCODER_ASSERT_SVH
`define BASE58_ENCODER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define B58_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define B58_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/b58_pkg.sv]
// types, constants and the alphabet function of the base58 encoder
package b58_pkg;

  localparam int unsigned MAX_BYTES_DEF = 64;
  localparam int unsigned DIG_W         = 6;

  // floor(v * RECIP / 2**RECIP_SHIFT) == floor(v / 58) for v < 2**14
  localparam logic [14:0] RECIP       = 15'd18079;
  localparam int unsigned RECIP_SHIFT = 20;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [63:0] text_chars;
    logic [3:0]  char_count;
    logic        last_word;
    logic        too_long;
  } out_t;

  // carry handed from one digit cell to the next more significant one
  typedef struct packed {
    logic       en;
    logic [7:0] carry;
  } cr_t;

  // one character beat into the packer
  typedef struct packed {
    logic       vld;
    logic [7:0] ch;
    logic       last;
    logic       too_long;
  } pk_req_t;

  function automatic logic [7:0] b58_char(input logic [DIG_W-1:0] d);
    logic [7:0] dv;
    dv = {2'b00, d};
    priority if (dv < 8'd9)  return 8'(dv + 8'h31);
    else if (dv < 8'd17)     return 8'(dv + 8'h38);
    else if (dv < 8'd22)     return 8'(dv + 8'h39);
    else if (dv < 8'd33)     return 8'(dv + 8'h3A);
    else if (dv < 8'd44)     return 8'(dv + 8'h40);
    else                     return 8'(dv + 8'h41);
  endfunction

endpackage

[sv/b58_cell.sv]
// one base-58 digit cell: digit*256+carry split into digit and carry, or shift
module b58_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clr,
  input  logic                        shift,
  input  logic [b58_pkg::DIG_W-1:0]   shift_in,
  input  b58_pkg::cr_t                cin,
  output b58_pkg::cr_t                cout,
  output logic [b58_pkg::DIG_W-1:0]   digit
);

  logic [b58_pkg::DIG_W-1:0] digit_r, digit_nxt;
  b58_pkg::cr_t              cout_r;
  logic [13:0]               val;
  logic [28:0]               prod;
  logic [7:0]                quo;
  logic [13:0]               quo58;
  logic [13:0]               rem;

  always_comb begin
    val   = {digit_r, 8'h00} + {6'd0, cin.carry};
    prod  = {15'd0, val} * {14'd0, b58_pkg::RECIP};
    quo   = prod[b58_pkg::RECIP_SHIFT+7:b58_pkg::RECIP_SHIFT];
    // 58 = 64 - 4 - 2
    quo58 = {quo, 6'b0} - {4'd0, quo, 2'b0} - {5'd0, quo, 1'b0};
    rem   = val - quo58;
    digit_nxt = digit_r;
    if (cin.en) begin
      digit_nxt = rem[b58_pkg::DIG_W-1:0];
    end else if (shift) begin
      digit_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      digit_r      <= '0;
      cout_r.en    <= 1'b0;
      cout_r.carry <= '0;
    end else begin
      digit_r      <= digit_nxt;
      cout_r.en    <= cin.en;
      cout_r.carry <= quo;
    end
  end

  assign cout  = cout_r;
  assign digit = digit_r;

endmodule

[sv/b58_packer.sv]
// packs characters eight to a result word and holds the output register
module b58_packer (
  input  logic             clk,
  input  logic             rst_n,
  input  b58_pkg::pk_req_t req,
  output logic             slot_free,
  output logic             out_valid,
  input  logic             out_ready,
  output b58_pkg::out_t    out_payload
);

  logic [2:0]    fill_r;
  logic [63:0]   word_r;
  logic [63:0]   word_ins;
  logic          load;
  logic          out_valid_r;
  b58_pkg::out_t res_r, res_nxt;

  always_comb begin
    word_ins = word_r;
    for (int i = 0; i < 8; i++) begin
      if (fill_r == 3'(i)) word_ins[8*i +: 8] = req.ch;
    end
    load = req.vld && (req.too_long || req.last || fill_r == 3'd7);
    if (req.too_long) begin
      res_nxt.text_chars = '0;
      res_nxt.char_count = '0;
      res_nxt.last_word  = 1'b1;
      res_nxt.too_long   = 1'b1;
    end else begin
      res_nxt.text_chars = word_ins;
      res_nxt.char_count = 4'({1'b0, fill_r} + 4'd1);
      res_nxt.last_word  = req.last;
      res_nxt.too_long   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      fill_r      <= '0;
      word_r      <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (load) begin
        fill_r <= '0;
        word_r <= '0;
      end else if (req.vld) begin
        fill_r <= 3'(fill_r + 3'd1);
        word_r <= word_ins;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= res_nxt;
  end

  assign slot_free   = !out_valid_r || out_ready;
  assign out_valid   = out_valid_r;
  assign out_payload = res_r;

endmodule

[sv/base58_encoder.sv]
// base58 encoder top level: control, digit cell chain and character packer
//
// Input channel in_valid/in_ready/in_data takes one message byte per beat,
// most significant first, with last_byte set on the final byte. Bytes are
// taken one per cycle: each byte after the leading zero bytes enters
// the least significant cell of a row of DIGITS = MAX_BYTES*138/100+1
// digit cells and its carry moves one cell per cycle, so folds of
// successive bytes overlap. After the final byte in_ready stays low
// while the message is drained, then one '1' beat per leading zero byte
// is produced, then the cells are shifted out most significant first,
// skipping leading zero digits. Characters are packed eight per out
// beat, the last beat flagged last_word. DIGITS is 89 at the default
// size. A message over MAX_BYTES gives one beat with too_long set and no
// characters. While out_ready is low with a beat held, character
// production pauses. Reset clears all cells and control; the first
// byte can be offered in the cycle after reset is released.
`include "base58_encoder_assert.svh"

module base58_encoder #(
  parameter int unsigned MAX_BYTES = b58_pkg::MAX_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  b58_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output b58_pkg::out_t out_payload
);

  localparam int unsigned DIGITS = (MAX_BYTES * 138) / 100 + 1;
  localparam int unsigned CNT_W  = $clog2(DIGITS + 1);
  localparam int unsigned LZ_W   = $clog2(MAX_BYTES + 1);
  localparam int unsigned BC_W   = $clog2(MAX_BYTES + 2);

  localparam logic [2:0] PH_ACCEPT  = 3'd0;
  localparam logic [2:0] PH_DRAIN   = 3'd1;
  localparam logic [2:0] PH_ONES    = 3'd2;
  localparam logic [2:0] PH_DIGITS  = 3'd3;
  localparam logic [2:0] PH_TOOLONG = 3'd4;

  logic [2:0]       phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [LZ_W-1:0]  lzc_r, lzc_nxt;
  logic [BC_W-1:0]  bc_r, bc_nxt;
  logic             seen_r, seen_nxt;
  logic             exc_r, exc_nxt;
  logic             started_r, started_nxt;
  logic             acc;
  logic             clr_s;
  logic             shift_s;
  logic             slot_free;
  logic             finish;
  b58_pkg::pk_req_t req;

  b58_pkg::cr_t               cr_s  [DIGITS+1];
  logic [b58_pkg::DIG_W-1:0]  dig_s [DIGITS];

  assign in_ready = (phase_r == PH_ACCEPT);
  assign acc      = in_valid && in_ready;
  assign cnt_inc  = CNT_W'(cnt_r + 1'b1);

  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    lzc_nxt     = lzc_r;
    bc_nxt      = bc_r;
    seen_nxt    = seen_r;
    exc_nxt     = exc_r;
    started_nxt = started_r;
    clr_s       = 1'b0;
    shift_s     = 1'b0;
    finish      = 1'b0;
    req         = '0;
    cr_s[DIGITS].en    = 1'b0;
    cr_s[DIGITS].carry = in_data.data_byte;

    unique case (phase_r)
      PH_ACCEPT: begin
        if (acc) begin
          if (bc_r >= BC_W'(MAX_BYTES)) begin
            exc_nxt = 1'b1;
          end else if (!seen_r && in_data.data_byte == 8'd0) begin
            lzc_nxt = LZ_W'(lzc_r + 1'b1);
          end else begin
            seen_nxt = 1'b1;
            cr_s[DIGITS].en = 1'b1;
          end
          if (bc_r < BC_W'(MAX_BYTES + 1)) bc_nxt = BC_W'(bc_r + 1'b1);
          if (in_data.last_byte) begin
            cnt_nxt   = '0;
            phase_nxt = exc_nxt ? PH_TOOLONG : PH_DRAIN;
          end
        end
      end
      PH_DRAIN: begin
        // wait for the final carry to reach the most significant cell
        cnt_nxt = cnt_inc;
        if (cnt_r == CNT_W'(DIGITS - 1)) begin
          cnt_nxt   = '0;
          phase_nxt = PH_ONES;
        end
      end
      PH_ONES: begin
        if (slot_free) begin
          if (cnt_r < CNT_W'(lzc_r)) begin
            req.vld  = 1'b1;
            req.ch   = 8'h31;
            req.last = !seen_r && (cnt_inc == CNT_W'(lzc_r));
            cnt_nxt  = cnt_inc;
            finish   = req.last;
          end else begin
            cnt_nxt     = '0;
            started_nxt = 1'b0;
            phase_nxt   = PH_DIGITS;
          end
        end
      end
      PH_DIGITS: begin
        if (slot_free) begin
          shift_s  = 1'b1;
          req.vld  = started_r || (dig_s[0] != '0);
          req.ch   = b58_pkg::b58_char(dig_s[0]);
          req.last = (cnt_r == CNT_W'(DIGITS - 1));
          if (req.vld) started_nxt = 1'b1;
          cnt_nxt = cnt_inc;
          finish  = req.last;
        end
      end
      PH_TOOLONG: begin
        if (slot_free) begin
          req.vld      = 1'b1;
          req.too_long = 1'b1;
          req.last     = 1'b1;
          clr_s        = 1'b1;
          finish       = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_ACCEPT;
      end
    endcase

    if (finish) begin
      phase_nxt = PH_ACCEPT;
      cnt_nxt   = '0;
      lzc_nxt   = '0;
      bc_nxt    = '0;
      seen_nxt  = 1'b0;
      exc_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_ACCEPT;
      cnt_r     <= '0;
      lzc_r     <= '0;
      bc_r      <= '0;
      seen_r    <= 1'b0;
      exc_r     <= 1'b0;
      started_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      lzc_r     <= lzc_nxt;
      bc_r      <= bc_nxt;
      seen_r    <= seen_nxt;
      exc_r     <= exc_nxt;
      started_r <= started_nxt;
    end
  end

  // index 0 is the most significant digit; shifting moves digits toward it
  for (genvar k = 0; k < DIGITS; k++) begin : g_cell
    logic [b58_pkg::DIG_W-1:0] sh_in;
    if (k == DIGITS - 1) begin : g_end
      assign sh_in = '0;
    end else begin : g_mid
      assign sh_in = dig_s[k+1];
    end
    b58_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .clr      (clr_s),
      .shift    (shift_s),
      .shift_in (sh_in),
      .cin      (cr_s[k+1]),
      .cout     (cr_s[k]),
      .digit    (dig_s[k])
    );
  end

  b58_packer u_packer (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req),
    .slot_free   (slot_free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_payload (out_payload)
  );

  `B58_ASSERT_IMPL(a_no_overflow, cr_s[0].en, cr_s[0].carry == 8'd0, "digit store overflow")
  `B58_ASSERT_NEXT(a_stop_after_last, acc && in_data.last_byte, !in_ready, "took byte after last")
  `B58_ASSERT_IMPL(a_full_word, out_valid && !out_payload.last_word, out_payload.char_count == 4'd8, "short word not last")
  `B58_ASSERT_IMPL(a_too_long_beat, out_valid && out_payload.too_long, out_payload.char_count == 4'd0 && out_payload.last_word, "bad too_long beat")

endmodule
